[rtl/wsc_pkg.sv]
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types, constants and the raised-cosine window table of the stereo
// crossfade unit.
// ----------------------------------------------------------------------------
package wsc_pkg;

	localparam int WINDOW_LEN = 36 * 32;
	localparam int FRAC_BITS  = 14;
	localparam int SAMPLE_W   = 16;

	localparam int WIN_AW = $clog2(WINDOW_LEN);
	localparam int WIN_W  = FRAC_BITS + 1;
	localparam int PROD_W = SAMPLE_W + WIN_W + 1;

	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	// Fixed-point angle math for building the window table.
	localparam int                 ANG_Q   = 30;
	localparam longint unsigned    PI_Q30  = 64'd3373259426;
	localparam longint unsigned    ANG_DEN = 64'(2 * WINDOW_LEN);
	localparam longint unsigned    TAYLOR_DIV [12] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
	};

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [WIN_AW-1:0]   win_addr_t;
	typedef logic        [WIN_W-1:0]    win_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef win_t                       win_rom_t [WINDOW_LEN];

	typedef struct packed {
		logic      fading;
		win_addr_t new_addr;
		win_addr_t old_addr;
	} fade_ctl_t;

	// Cosine of an angle in [0, pi/2], both in Q30, by a Taylor series.
	function automatic longint cos_q30(input longint unsigned theta);
		longint unsigned t2;
		longint unsigned term;
		longint          sum;
		t2   = (theta * theta) >> ANG_Q;
		term = 64'd1 << ANG_Q;
		sum  = longint'(term);
		for (int k = 1; k <= 12; k++) begin
			term = (term * t2) >> ANG_Q;
			term = term / TAYLOR_DIV[k-1];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	// 0.5 + 0.5*cos(pi*i/N) is evaluated as cos^2(pi*i/(2N)).
	function automatic win_t window_value(input int idx);
		longint unsigned theta;
		longint          c;
		longint unsigned cu;
		longint unsigned sq;
		theta = (PI_Q30 * longint'(idx)) / ANG_DEN;
		c     = cos_q30(theta);
		if (c < 0) begin
			c = 0;
		end
		if (c > (longint'(1) << ANG_Q)) begin
			c = longint'(1) << ANG_Q;
		end
		cu = longint'(c);
		sq = cu * cu;
		return WIN_W'(sq >> (2 * ANG_Q - FRAC_BITS));
	endfunction

	function automatic win_rom_t build_window();
		win_rom_t rom;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			rom[i] = window_value(i);
		end
		return rom;
	endfunction

	localparam win_rom_t WIN_ROM = build_window();

endpackage

[rtl/wsc_frame_if.sv]
// ----------------------------------------------------------------------------
// wsc_frame_if
// Input channel: one stereo frame of the old and the new stream.
// ----------------------------------------------------------------------------
interface wsc_frame_if import wsc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t old_left;
	sample_t old_right;
	sample_t new_left;
	sample_t new_right;
	logic    start_fade;

	modport source (
		output valid, old_left, old_right, new_left, new_right, start_fade,
		input  ready
	);
	modport sink (
		input  valid, old_left, old_right, new_left, new_right, start_fade,
		output ready
	);
endinterface

[rtl/wsc_mix_if.sv]
// ----------------------------------------------------------------------------
// wsc_mix_if
// Output channel: one mixed stereo frame and its fade flag.
// ----------------------------------------------------------------------------
interface wsc_mix_if import wsc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t mixed_left;
	sample_t mixed_right;
	logic    fading;

	modport source (
		output valid, mixed_left, mixed_right, fading,
		input  ready
	);
	modport sink (
		input  valid, mixed_left, mixed_right, fading,
		output ready
	);
endinterface

[rtl/wsc_fade_ctrl.sv]
// ----------------------------------------------------------------------------
// wsc_fade_ctrl
// Tracks the fade position and produces the two window addresses for the
// frame presented at the input.
// ----------------------------------------------------------------------------
module wsc_fade_ctrl import wsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic      start_fade,
	output fade_ctl_t ctl
);

	localparam win_addr_t LAST_POS = WIN_AW'(WINDOW_LEN - 1);

	win_addr_t pos_q;
	logic      active_q;
	win_addr_t pos_cur;
	logic      last_pos;

	// A start flag restarts the fade at position zero with this frame.
	assign pos_cur      = start_fade ? '0 : pos_q;
	assign last_pos     = (pos_cur == LAST_POS);
	assign ctl.fading   = start_fade | active_q;
	assign ctl.new_addr = pos_cur;
	assign ctl.old_addr = LAST_POS - pos_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
		end else if (accept && ctl.fading) begin
			if (last_pos) begin
				pos_q    <= '0;
				active_q <= 1'b0;
			end else begin
				pos_q    <= pos_cur + 1'b1;
				active_q <= 1'b1;
			end
		end
	end

endmodule

[rtl/wsc_win_rom.sv]
// ----------------------------------------------------------------------------
// wsc_win_rom
// Raised-cosine window table with two registered read ports.
// ----------------------------------------------------------------------------
module wsc_win_rom import wsc_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  win_addr_t addr_a,
	input  win_addr_t addr_b,
	output win_t      data_a,
	output win_t      data_b
);

	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= WIN_ROM[addr_a];
			data_b <= WIN_ROM[addr_b];
		end
	end

endmodule

[rtl/wsc_mix_lane.sv]
// ----------------------------------------------------------------------------
// wsc_mix_lane
// One audio channel: weights both samples, sums, scales back and saturates,
// or passes the old sample through outside a fade.
// ----------------------------------------------------------------------------
module wsc_mix_lane import wsc_pkg::*; (
	input  logic    clk,
	input  logic    en_s2,
	input  logic    en_out,
	input  sample_t old_s1,
	input  sample_t new_s1,
	input  win_t    w_old_s1,
	input  win_t    w_new_s1,
	input  logic    fade_s2,
	output sample_t mixed
);

	localparam int SUM_W = PROD_W + 1;
	localparam int SHR_W = SUM_W - FRAC_BITS;

	prod_t                   prod_old_s2;
	prod_t                   prod_new_s2;
	sample_t                 pass_s2;
	logic signed [SUM_W-1:0] sum;
	logic signed [SHR_W-1:0] scaled;
	sample_t                 sat;
	sample_t                 mixed_q;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_old_s2 <= PROD_W'(old_s1 * $signed({1'b0, w_old_s1}));
			prod_new_s2 <= PROD_W'(new_s1 * $signed({1'b0, w_new_s1}));
			pass_s2     <= old_s1;
		end
	end

	// The arithmetic shift rounds toward minus infinity.
	assign sum    = SUM_W'(prod_old_s2) + SUM_W'(prod_new_s2);
	assign scaled = SHR_W'(sum >>> FRAC_BITS);

	always_comb begin
		if (scaled > SHR_W'(SAT_MAX)) begin
			sat = SAMPLE_W'(SAT_MAX);
		end else if (scaled < SHR_W'(SAT_MIN)) begin
			sat = SAMPLE_W'(SAT_MIN);
		end else begin
			sat = SAMPLE_W'(scaled);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			mixed_q <= fade_s2 ? sat : pass_s2;
		end
	end

	assign mixed = mixed_q;

endmodule

[rtl/windowed_stereo_crossfade_unit.sv]
// ----------------------------------------------------------------------------
// windowed_stereo_crossfade_unit
// Raised-cosine crossfade between two stereo 16-bit streams.
// ----------------------------------------------------------------------------
// Each transaction on in_frame carries the old and the new stream's left and
// right samples. A frame with start_fade high starts a fade of WINDOW_LEN
// frames at position zero, also in the middle of a running fade. During the
// fade the old sample is weighted by the rising half of the window and the
// new one by the falling half; the sum is scaled back and saturated to 16
// bits. Outside a fade the old samples pass through and fading is low.
// Every input transaction gives exactly one transaction on mix_out.
// The path has three register stages (window ROM read and input register,
// products, output register). One frame is accepted per cycle while
// mix_out does not stall; the rate is set by the single pass through the
// two ROM ports and the four multipliers.
// When mix_out stalls, the stages fill up and in_frame.ready drops only
// once all three hold a frame. Reset clears the stage valids and ends any
// fade; the window table is constant and needs no loading.
// ----------------------------------------------------------------------------
module windowed_stereo_crossfade_unit import wsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wsc_frame_if.sink   in_frame,
	wsc_mix_if.source   mix_out
);

	fade_ctl_t ctl;
	logic      accept;
	logic      en_s1;
	logic      en_s2;
	logic      en_out;

	logic      valid_s1;
	logic      valid_s2;
	logic      valid_q;
	logic      fade_s1;
	logic      fade_s2;
	logic      fading_q;
	sample_t   old_l_s1;
	sample_t   old_r_s1;
	sample_t   new_l_s1;
	sample_t   new_r_s1;
	win_t      w_old_s1;
	win_t      w_new_s1;

	// Each stage moves when it is empty or the stage after it moves.
	assign en_out = !valid_q || mix_out.ready;
	assign en_s2  = !valid_s2 || en_out;
	assign en_s1  = !valid_s1 || en_s2;

	assign in_frame.ready = en_s1;
	assign accept         = in_frame.valid && en_s1;

	wsc_fade_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.start_fade (in_frame.start_fade),
		.ctl        (ctl)
	);

	wsc_win_rom u_rom (
		.clk    (clk),
		.en     (en_s1),
		.addr_a (ctl.old_addr),
		.addr_b (ctl.new_addr),
		.data_a (w_old_s1),
		.data_b (w_new_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_frame.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			old_l_s1 <= in_frame.old_left;
			old_r_s1 <= in_frame.old_right;
			new_l_s1 <= in_frame.new_left;
			new_r_s1 <= in_frame.new_right;
			fade_s1  <= ctl.fading;
		end
		if (en_s2) begin
			fade_s2 <= fade_s1;
		end
		if (en_out) begin
			fading_q <= fade_s2;
		end
	end

	wsc_mix_lane u_lane_left (
		.clk      (clk),
		.en_s2    (en_s2),
		.en_out   (en_out),
		.old_s1   (old_l_s1),
		.new_s1   (new_l_s1),
		.w_old_s1 (w_old_s1),
		.w_new_s1 (w_new_s1),
		.fade_s2  (fade_s2),
		.mixed    (mix_out.mixed_left)
	);

	wsc_mix_lane u_lane_right (
		.clk      (clk),
		.en_s2    (en_s2),
		.en_out   (en_out),
		.old_s1   (old_r_s1),
		.new_s1   (new_r_s1),
		.w_old_s1 (w_old_s1),
		.w_new_s1 (w_new_s1),
		.fade_s2  (fade_s2),
		.mixed    (mix_out.mixed_right)
	);

	assign mix_out.valid  = valid_q;
	assign mix_out.fading = fading_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the raised-cosine stereo crossfade unit.
// A short table of hand-picked frames runs first, then about fifteen hundred
// random frames that include one complete fade and several restarts. Every
// frame is run through a local model of the fade, and each output transaction
// is compared field by field with the oldest predicted frame. Both channels
// idle and stall at random in changing phases.
// ----------------------------------------------------------------------------
module testbench;
	import wsc_pkg::*;

	localparam int              ANGLE_Q    = 30;
	localparam longint unsigned ANGLE_PI   = 64'd3373259426;
	localparam longint unsigned ANGLE_ONE  = 64'd1 << ANGLE_Q;
	localparam int              RAND_ITEMS = 1500;
	localparam int              HOLD_AT    = 600;
	localparam int              DRAIN_AT   = 1300;
	localparam int              HOLD_LEN   = 64;

	typedef struct packed {
		sample_t old_left;
		sample_t old_right;
		sample_t new_left;
		sample_t new_right;
		logic    start_fade;
	} frame_t;

	typedef struct packed {
		sample_t mixed_left;
		sample_t mixed_right;
		logic    fading;
	} mix_t;

	typedef struct {
		frame_t frame;
		bit     pinned;
		mix_t   pin;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	wsc_frame_if frame_ch ();
	wsc_mix_if   mix_ch ();

	windowed_stereo_crossfade_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_frame (frame_ch),
		.mix_out  (mix_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the window and the fade state.
	int         window_gain [WINDOW_LEN];
	logic [10:0] fade_pos;
	logic        fade_on;

	mix_t      mix_q [$];
	stim_row_t stim_rows [$];
	mix_t      head_mix;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 1'b0;
	int rand_count     = 0;

	int errors       = 0;
	int frames_sent  = 0;
	int blended_seen = 0;
	int passed_seen  = 0;
	int fade_starts  = 0;
	int fade_ends    = 0;

	// The window is cos^2(pi*i/(2N)) in Q14, with the cosine taken from a
	// truncated Taylor series in Q30 integer arithmetic.
	initial begin : gain_table
		longint unsigned theta;
		longint unsigned theta_sq;
		longint unsigned term;
		longint unsigned mag;
		longint          cosine;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			theta    = (ANGLE_PI * 64'(i)) / 64'(2 * WINDOW_LEN);
			theta_sq = (theta * theta) >> ANGLE_Q;
			term     = ANGLE_ONE;
			cosine   = longint'(ANGLE_ONE);
			for (int k = 1; k <= 12; k++) begin
				term = ((term * theta_sq) >> ANGLE_Q) / 64'((2 * k - 1) * (2 * k));
				if (k % 2 == 1) begin
					cosine = cosine - longint'(term);
				end else begin
					cosine = cosine + longint'(term);
				end
			end
			if (cosine < 0) begin
				cosine = 0;
			end
			if (cosine > longint'(ANGLE_ONE)) begin
				cosine = longint'(ANGLE_ONE);
			end
			mag = 64'(cosine);
			window_gain[i] = int'((mag * mag) >> (2 * ANGLE_Q - FRAC_BITS));
		end
	end

	function automatic sample_t blend_sample(sample_t old_s, sample_t new_s, int pos);
		longint acc;
		acc = longint'(old_s) * longint'(window_gain[WINDOW_LEN - 1 - pos])
		    + longint'(new_s) * longint'(window_gain[pos]);
		acc = acc >>> FRAC_BITS;
		if (acc > SAT_MAX) begin
			acc = SAT_MAX;
		end else if (acc < SAT_MIN) begin
			acc = SAT_MIN;
		end
		return sample_t'(acc);
	endfunction

	function automatic mix_t predict_mix(frame_t f);
		mix_t r;
		if (f.start_fade) begin
			fade_pos = '0;
			fade_on  = 1'b1;
			fade_starts++;
		end
		if (fade_pos >= WINDOW_LEN) begin
			fade_pos = '0;
		end
		if (fade_on) begin
			r.mixed_left  = blend_sample(f.old_left, f.new_left, int'(fade_pos));
			r.mixed_right = blend_sample(f.old_right, f.new_right, int'(fade_pos));
			r.fading      = 1'b1;
			fade_pos++;
			if (fade_pos >= WINDOW_LEN) begin
				fade_pos = '0;
				fade_on  = 1'b0;
				fade_ends++;
			end
		end else begin
			r.mixed_left  = f.old_left;
			r.mixed_right = f.old_right;
			r.fading      = 1'b0;
		end
		return r;
	endfunction

	function automatic void add_row(sample_t o_l, sample_t o_r, sample_t n_l, sample_t n_r,
			logic start, bit pinned, sample_t e_l, sample_t e_r, logic e_fade);
		stim_row_t row;
		row.frame.old_left   = o_l;
		row.frame.old_right  = o_r;
		row.frame.new_left   = n_l;
		row.frame.new_right  = n_r;
		row.frame.start_fade = start;
		row.pinned           = pinned;
		row.pin.mixed_left   = e_l;
		row.pin.mixed_right  = e_r;
		row.pin.fading       = e_fade;
		stim_rows.push_back(row);
	endfunction

	// Extremes and small values show up often; the rest is uniform.
	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0: return sample_t'(SAT_MIN);
			1: return sample_t'(SAT_MAX);
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_frame(frame_t f, bit pinned, mix_t pin);
		mix_t want;
		if ($urandom_range(99) < send_idle_pct) begin
			frame_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		frame_ch.valid      <= 1'b1;
		frame_ch.old_left   <= f.old_left;
		frame_ch.old_right  <= f.old_right;
		frame_ch.new_left   <= f.new_left;
		frame_ch.new_right  <= f.new_right;
		frame_ch.start_fade <= f.start_fade;
		do @(posedge clk); while (!frame_ch.ready);
		want = predict_mix(f);
		if (pinned) begin
			want = pin;
		end
		mix_q.push_back(want);
		frames_sent++;
	endtask

	// Holds the input low until every frame in flight has come out.
	task automatic drain_pipeline();
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (mix_q.size() != 0);
	endtask

	task automatic send_random(logic start);
		frame_t f;
		case ((rand_count / 100) % 4)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 55;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 55;
			end
			default: begin
				send_idle_pct  = 16;
				recv_stall_pct = 16;
			end
		endcase
		if (rand_count == HOLD_AT) begin
			hold_request = 1'b1;
		end
		if (rand_count == DRAIN_AT) begin
			drain_pipeline();
		end
		f.old_left   = pick_sample();
		f.old_right  = pick_sample();
		f.new_left   = pick_sample();
		f.new_right  = pick_sample();
		f.start_fade = start;
		send_frame(f, 1'b0, '0);
		rand_count++;
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		mix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_LEN;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				mix_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				mix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && mix_ch.valid && mix_ch.ready) begin
			if (mix_q.size() == 0) begin
				$display("%0t ns: output transaction with nothing expected: %0d %0d %0b",
					$time, mix_ch.mixed_left, mix_ch.mixed_right, mix_ch.fading);
				errors++;
			end else begin
				head_mix = mix_q.pop_front();
				if (mix_ch.mixed_left !== head_mix.mixed_left) begin
					$display("%0t ns: mixed_left expected %0d, got %0d",
						$time, head_mix.mixed_left, mix_ch.mixed_left);
					errors++;
				end
				if (mix_ch.mixed_right !== head_mix.mixed_right) begin
					$display("%0t ns: mixed_right expected %0d, got %0d",
						$time, head_mix.mixed_right, mix_ch.mixed_right);
					errors++;
				end
				if (mix_ch.fading !== head_mix.fading) begin
					$display("%0t ns: fading expected %0b, got %0b",
						$time, head_mix.fading, mix_ch.fading);
					errors++;
				end
				if (head_mix.fading) begin
					blended_seen++;
				end else begin
					passed_seen++;
				end
			end
		end
	end

	initial begin : stimulus
		fade_pos = '0;
		fade_on  = 1'b0;
		arst_n              <= 1'b0;
		frame_ch.valid      <= 1'b0;
		frame_ch.old_left   <= '0;
		frame_ch.old_right  <= '0;
		frame_ch.new_left   <= '0;
		frame_ch.new_right  <= '0;
		frame_ch.start_fade <= 1'b0;

		// Passthrough after reset, then a start (the new samples come out
		// unchanged at position zero), then restarts in the middle of a fade.
		add_row(32767, -32768, 0, 0, 1'b0, 1, 32767, -32768, 1'b0);
		add_row(-32768, 32767, 32767, -32768, 1'b0, 1, -32768, 32767, 1'b0);
		add_row(-1, 0, -1, 0, 1'b0, 1, -1, 0, 1'b0);
		add_row(21845, -21846, -1, 1, 1'b0, 1, 21845, -21846, 1'b0);
		add_row(12345, -12345, 32767, -32768, 1'b1, 1, 32767, -32768, 1'b1);
		add_row(-32768, -32768, -32768, -32768, 1'b0, 0, 0, 0, 1'b0);
		add_row(32767, 32767, 32767, 32767, 1'b0, 0, 0, 0, 1'b0);
		add_row(32767, -32768, -32768, 32767, 1'b0, 0, 0, 0, 1'b0);
		add_row(0, 0, 0, 0, 1'b0, 1, 0, 0, 1'b1);
		add_row(-1, -1, -1, -1, 1'b0, 0, 0, 0, 1'b0);
		add_row(-32768, 32767, -32768, 32767, 1'b1, 1, -32768, 32767, 1'b1);
		add_row(0, 0, 1, -1, 1'b1, 1, 1, -1, 1'b1);
		add_row(-32768, 32767, 32767, -32768, 1'b0, 0, 0, 0, 1'b0);
		add_row(12345, 23456, -23456, -12345, 1'b0, 0, 0, 0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			send_frame(stim_rows[r].frame, stim_rows[r].pinned, stim_rows[r].pin);
		end
		drain_pipeline();

		// One fade that runs past its last window position without a restart.
		for (int n = 0; n < WINDOW_LEN + 30; n++) begin
			send_random(n == 0);
		end
		while (rand_count < RAND_ITEMS) begin
			send_random($urandom_range(39) == 0);
		end

		frame_ch.valid <= 1'b0;
		while (mix_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mix_q.size() != 0) begin
			$display("%0t ns: %0d expected frames never came out", $time, mix_q.size());
			errors++;
		end

		$display("Sent %0d frames: %0d came out blended, %0d passed through.",
			frames_sent, blended_seen, passed_seen);
		$display("Fades started: %0d, fades run to the end: %0d, mismatches: %0d.",
			fade_starts, fade_ends, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Timed out with %0d frames still expected.", mix_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
